// ===== design/mcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_pkg
// Shared types and constants of the methylation context caller: base codes,
// call codes and the word passed from the window stage to the classifier.
// ----------------------------------------------------------------------------
package mcc_pkg;

   localparam int BASE_W = 8;
   localparam int CODE_W = 4;
   localparam int POS_W  = 10;

   typedef logic [BASE_W-1:0] base_type;
   typedef logic [CODE_W-1:0] code_type;
   typedef logic [POS_W-1:0]  pos_type;

   // ASCII bases
   localparam base_type BASE_A = base_type'(8'h41);
   localparam base_type BASE_C = base_type'(8'h43);
   localparam base_type BASE_G = base_type'(8'h47);
   localparam base_type BASE_T = base_type'(8'h54);

   // call codes; the unmethylated code of each context is its methylated one plus one
   localparam code_type CODE_NONE       = code_type'(0);
   localparam code_type CODE_CPG_METH   = code_type'(1);
   localparam code_type CODE_CHG_METH   = code_type'(3);
   localparam code_type CODE_CHH_METH   = code_type'(5);
   localparam code_type CODE_MISMATCH   = code_type'(7);
   localparam code_type CODE_OTHER_METH = code_type'(8);
   localparam code_type CODE_OTHER_UNME = code_type'(9);

   // column under judgement together with the two genome bases after it
   typedef struct packed {
      logic     judge;
      base_type read_base;
      base_type next_genome;
      base_type after_genome;
      pos_type  position;
   } judge_type;

   function automatic logic is_h_base(base_type b);
      return (b == BASE_A) || (b == BASE_C) || (b == BASE_T);
   endfunction

endpackage

// ===== design/mcc_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_window
// Two-column window and column counter; registers the column due for a call.
// ----------------------------------------------------------------------------
module mcc_window #(
   parameter int MAX_READ_LEN = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  mcc_pkg::base_type    read_base,
   input  mcc_pkg::base_type    genome_base,
   input  logic                 first_of_read,
   output mcc_pkg::judge_type   judge
);

   localparam int CW = $clog2(MAX_READ_LEN + 3);
   localparam logic [CW-1:0] COUNT_LIMIT = CW'(MAX_READ_LEN + 2);
   localparam logic [CW-1:0] COUNT_TWO   = CW'(2);

   mcc_pkg::base_type genome_win_ff [2];
   mcc_pkg::base_type read_win_ff   [2];
   logic [CW-1:0]     count_ff, count_in;
   mcc_pkg::judge_type judge_ff, judge_in;

   mcc_pkg::base_type g_near, g_far, r_near, r_far;
   logic [CW-1:0]     count_cur, offset;

   always_comb begin
      // a first mark clears the window before this column is looked at
      g_near    = first_of_read ? '0 : genome_win_ff[0];
      g_far     = first_of_read ? '0 : genome_win_ff[1];
      r_near    = first_of_read ? '0 : read_win_ff[0];
      r_far     = first_of_read ? '0 : read_win_ff[1];
      count_cur = first_of_read ? '0 : count_ff;
      offset    = count_cur - COUNT_TWO;

      judge_in.judge        = (count_cur >= COUNT_TWO) && (count_cur < COUNT_LIMIT) &&
                              (g_far == mcc_pkg::BASE_C);
      judge_in.read_base    = r_far;
      judge_in.next_genome  = g_near;
      judge_in.after_genome = genome_base;
      judge_in.position     = mcc_pkg::POS_W'(offset);

      // saturate at the limit
      count_in = (count_cur < COUNT_LIMIT) ? count_cur + CW'(1) : count_cur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         genome_win_ff[0] <= '0;
         genome_win_ff[1] <= '0;
         read_win_ff[0]   <= '0;
         read_win_ff[1]   <= '0;
         count_ff         <= '0;
      end else if (load) begin
         genome_win_ff[1] <= g_near;
         genome_win_ff[0] <= genome_base;
         read_win_ff[1]   <= r_near;
         read_win_ff[0]   <= read_base;
         count_ff         <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         judge_ff <= judge_in;
      end
   end

   assign judge = judge_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_LIMIT)
      else $error("column count past its limit");

   a_first_restarts: assert property (@(posedge clock) disable iff (reset)
      load && first_of_read |=> count_ff == CW'(1) && !judge_ff.judge)
      else $error("first column of a read did not restart the window");

   a_early_no_call: assert property (@(posedge clock) disable iff (reset)
      load && count_cur < COUNT_TWO |=> !judge_ff.judge)
      else $error("call raised before the window filled");

endmodule

// ===== design/mcc_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_classify
// Context and state decision for one judged column.
// ----------------------------------------------------------------------------
module mcc_classify (
   input  mcc_pkg::judge_type judge,
   output mcc_pkg::code_type  call_code,
   output mcc_pkg::pos_type   call_position
);

   mcc_pkg::code_type ctx_base;
   logic              unmeth;

   always_comb begin
      if (judge.next_genome == mcc_pkg::BASE_G) begin
         ctx_base = mcc_pkg::CODE_CPG_METH;
      end else if (mcc_pkg::is_h_base(judge.next_genome) &&
                   judge.after_genome == mcc_pkg::BASE_G) begin
         ctx_base = mcc_pkg::CODE_CHG_METH;
      end else if (mcc_pkg::is_h_base(judge.next_genome) &&
                   mcc_pkg::is_h_base(judge.after_genome)) begin
         ctx_base = mcc_pkg::CODE_CHH_METH;
      end else begin
         ctx_base = mcc_pkg::CODE_OTHER_METH;
      end

      unmeth = (judge.read_base == mcc_pkg::BASE_T);

      if (!judge.judge) begin
         call_code     = mcc_pkg::CODE_NONE;
         call_position = '0;
      end else begin
         call_position = judge.position;
         if (judge.read_base == mcc_pkg::BASE_C || unmeth) begin
            call_code = ctx_base + mcc_pkg::CODE_W'(unmeth);
         end else begin
            call_code = mcc_pkg::CODE_MISMATCH;
         end
      end
   end

endmodule

// ===== design/methylation_context_caller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// methylation_context_caller_unit
// Bisulfite methylation context caller over a stream of aligned columns.
// ----------------------------------------------------------------------------
// Feed one aligned column per word (read base, genome base, first-of-read
// mark); every accepted word returns exactly one result word, in order. The
// result judges the column two words back: if its genome base is C it carries
// the context (CpG, CHG, CHH or other) and the state (C methylated, T
// unmethylated, other read base a mismatch) with the column's offset in the
// read; otherwise code 0 and position 0. The first two words of a read
// give no call, and columns at offset MAX_READ_LEN or beyond give none either.
// A new word is taken every clock cycle while the result side is not stalled.
// A word passes through the window register, which holds the two previous
// columns and the column count, and then the result register after the
// classifier. Both stages hold under back-pressure, so up to two words may
// be in flight while the result side stalls.
// ----------------------------------------------------------------------------
module methylation_context_caller_unit #(
   parameter int MAX_READ_LEN = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_read_base,
   input  logic [7:0] req_genome_base,
   input  logic       req_first_of_read,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_call_code,
   output logic [9:0] rsp_call_position
);

   logic               win_valid_ff, win_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_take, rsp_load;
   mcc_pkg::judge_type judge;
   mcc_pkg::code_type  code_in, code_ff;
   mcc_pkg::pos_type   pos_in, pos_ff;

   // result register takes a word when empty or being drained
   assign rsp_load  = win_valid_ff && (!rsp_valid_ff || rsp_ready);
   // window stage takes a word when empty or passing its word on
   assign req_ready = !win_valid_ff || rsp_load;
   assign req_take  = req_valid && req_ready;

   mcc_window #(
      .MAX_READ_LEN (MAX_READ_LEN)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .load          (req_take),
      .read_base     (req_read_base),
      .genome_base   (req_genome_base),
      .first_of_read (req_first_of_read),
      .judge         (judge)
   );

   mcc_classify u_classify (
      .judge         (judge),
      .call_code     (code_in),
      .call_position (pos_in)
   );

   always_comb begin
      // advance the window stage on a new word, drop it once handed on
      win_valid_in = req_take ? 1'b1 : (rsp_load ? 1'b0 : win_valid_ff);
      // hold a result until taken
      rsp_valid_in = rsp_load ? 1'b1 : ((rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_valid_ff <= win_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         code_ff <= code_in;
         pos_ff  <= pos_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_call_code     = code_ff;
   assign rsp_call_position = pos_ff;

   a_none_zero_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && code_ff == mcc_pkg::CODE_NONE |-> pos_ff == '0)
      else $error("no-call result with non-zero position");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> code_ff <= mcc_pkg::CODE_OTHER_UNME)
      else $error("call code out of range");

   a_window_hold: assert property (@(posedge clock) disable iff (reset)
      win_valid_ff && !rsp_load && !req_take |=> win_valid_ff && $stable(judge))
      else $error("stalled window word lost or changed");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(code_ff) && $stable(pos_ff))
      else $error("pending result overwritten");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for methylation_context_caller_unit.
// ----------------------------------------------------------------------------
// A queue of aligned columns is built at time zero. It starts with a short
// directed set: a read with no first mark straight after reset, every context
// in both states, a mismatch, lower case and N bytes, and reads of one
// and two columns. Random reads follow: mostly well-formed reads with bases
// weighted towards C and G, some noise words with raw bytes and stray first
// marks, and one read long enough to run past MAX_READ_LEN. A clocked driver
// feeds the block and predicts each call as its word is accepted. A clocked
// monitor compares each result word with the oldest predicted call. Both
// sides idle at random, apart from one calm stretch.
// ----------------------------------------------------------------------------
module tb;

   localparam int                READ_LIMIT    = 1024;
   localparam int                WORD_TARGET   = 1975;
   localparam int                LONG_READ_LEN = 1100;
   localparam int                STALL_LIMIT   = 1000;
   localparam int                DRAIN_CYCLES  = 10;
   localparam mcc_pkg::base_type BASE_N        = mcc_pkg::base_type'(8'h4E);
   localparam mcc_pkg::base_type BASE_GAP      = mcc_pkg::base_type'(8'h2D);
   localparam mcc_pkg::base_type BASE_LOWER_C  = mcc_pkg::base_type'(8'h63);
   localparam mcc_pkg::base_type BASE_LOWER_G  = mcc_pkg::base_type'(8'h67);

   typedef struct {
      mcc_pkg::base_type read_base;
      mcc_pkg::base_type genome_base;
      logic              first_of_read;
   } column_word_type;

   typedef struct {
      mcc_pkg::code_type code;
      mcc_pkg::pos_type  position;
   } call_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_read_base = 8'h00;
   logic [7:0] req_genome_base = 8'h00;
   logic       req_first_of_read = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [3:0] rsp_call_code;
   logic [9:0] rsp_call_position;

   column_word_type pending_columns[$];
   call_word_type   expected_calls[$];
   int              words_queued = 0;
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              stall_cycles = 0;
   logic            calm;

   // predictor state: the two previous columns and the saturating count
   mcc_pkg::base_type genome_hist[2];
   mcc_pkg::base_type read_hist[2];
   logic [10:0]       column_total;

   column_word_type next_column;
   call_word_type   seen_call;
   call_word_type   oldest_call;

   methylation_context_caller_unit #(
      .MAX_READ_LEN(READ_LIMIT)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_read_base(req_read_base),
      .req_genome_base(req_genome_base),
      .req_first_of_read(req_first_of_read),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_call_code(rsp_call_code),
      .rsp_call_position(rsp_call_position)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // no idling on either side through this stretch
   assign calm = (cycle_count >= 1200) && (cycle_count < 1800);

   // ---------------------------------------------------------------------
   // call predictor
   // ---------------------------------------------------------------------
   function automatic mcc_pkg::code_type context_of(mcc_pkg::base_type next_g,
                                                     mcc_pkg::base_type after_g);
      if (next_g == mcc_pkg::BASE_G)
         return mcc_pkg::CODE_CPG_METH;
      if (next_g inside {mcc_pkg::BASE_A, mcc_pkg::BASE_C, mcc_pkg::BASE_T}) begin
         if (after_g == mcc_pkg::BASE_G)
            return mcc_pkg::CODE_CHG_METH;
         if (after_g inside {mcc_pkg::BASE_A, mcc_pkg::BASE_C, mcc_pkg::BASE_T})
            return mcc_pkg::CODE_CHH_METH;
      end
      return mcc_pkg::CODE_OTHER_METH;
   endfunction

   task automatic predict_call(input mcc_pkg::base_type rb, input mcc_pkg::base_type gb,
                               input logic first);
      call_word_type c;
      int            offset;
      c.code = mcc_pkg::CODE_NONE;
      c.position = '0;
      // a first mark clears the window before the column is judged
      if (first) begin
         genome_hist[0] = '0;
         genome_hist[1] = '0;
         read_hist[0] = '0;
         read_hist[1] = '0;
         column_total = '0;
      end
      // judge the column two words back against this and the previous genome base
      if (column_total >= 11'(2)) begin
         offset = int'(column_total) - 2;
         if (offset < READ_LIMIT && genome_hist[1] == mcc_pkg::BASE_C) begin
            if (read_hist[1] == mcc_pkg::BASE_C)
               c.code = context_of(genome_hist[0], gb);
            else if (read_hist[1] == mcc_pkg::BASE_T)
               c.code = mcc_pkg::code_type'(context_of(genome_hist[0], gb) + 4'd1);
            else
               c.code = mcc_pkg::CODE_MISMATCH;
            c.position = mcc_pkg::pos_type'(offset);
         end
      end
      genome_hist[1] = genome_hist[0];
      genome_hist[0] = gb;
      read_hist[1] = read_hist[0];
      read_hist[0] = rb;
      if (int'(column_total) < READ_LIMIT + 2)
         column_total = column_total + 11'd1;
      expected_calls.push_back(c);
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------
   task automatic push_column(input mcc_pkg::base_type rb, input mcc_pkg::base_type gb,
                              input logic first);
      column_word_type w;
      w.read_base = rb;
      w.genome_base = gb;
      w.first_of_read = first;
      pending_columns.push_back(w);
      words_queued++;
   endtask

   task automatic push_read(input string genome, input string bases, input logic mark);
      for (int i = 0; i < genome.len(); i++)
         push_column(mcc_pkg::base_type'(bases[i]), mcc_pkg::base_type'(genome[i]),
                     (i == 0) ? mark : 1'b0);
   endtask

   function automatic mcc_pkg::base_type pick_genome();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 35) return mcc_pkg::BASE_C;
      if (roll < 60) return mcc_pkg::BASE_G;
      if (roll < 72) return mcc_pkg::BASE_A;
      if (roll < 86) return mcc_pkg::BASE_T;
      case ($urandom_range(4))
         0: return BASE_N;
         1: return BASE_GAP;
         2: return BASE_LOWER_C;
         3: return BASE_LOWER_G;
         default: return mcc_pkg::base_type'($urandom_range(255));
      endcase
   endfunction

   // read base mostly follows bisulfite conversion: C or T over a genome C
   function automatic mcc_pkg::base_type pick_read(mcc_pkg::base_type gb);
      int unsigned roll;
      roll = $urandom_range(99);
      if (gb == mcc_pkg::BASE_C) begin
         if (roll < 45) return mcc_pkg::BASE_C;
         if (roll < 90) return mcc_pkg::BASE_T;
      end else if (roll < 75) begin
         return gb;
      end
      case ($urandom_range(5))
         0: return mcc_pkg::BASE_A;
         1: return mcc_pkg::BASE_G;
         2: return BASE_N;
         3: return mcc_pkg::BASE_C;
         4: return mcc_pkg::BASE_T;
         default: return mcc_pkg::base_type'($urandom_range(255));
      endcase
   endfunction

   task automatic push_random_read(input int len, input logic tidy);
      mcc_pkg::base_type gb;
      for (int i = 0; i < len; i++) begin
         if (tidy) begin
            gb = pick_genome();
            push_column(pick_read(gb), gb, i == 0);
         end else begin
            // noise: raw bytes and the odd stray first mark
            push_column(mcc_pkg::base_type'($urandom_range(255)),
                        mcc_pkg::base_type'($urandom_range(255)),
                        (i == 0) || ($urandom_range(19) == 0));
         end
      end
   endtask

   task automatic build_stimulus();
      logic long_done;
      long_done = 1'b0;
      // reset acts as the start of a read: no first mark on the opening read
      push_read("CGCGCAGCATCANCTG", "CATACAGCATTAGTTA", 1'b0);
      // CHH unmethylated, a mismatch in CHG context and CpG methylated
      push_read("CTACCGG", "TAAGCAA", 1'b1);
      // lower case context counts as other
      push_read("Ccg", "CAA", 1'b1);
      // byte extremes, a read of one column and a read of two
      push_column(8'hFF, 8'h00, 1'b1);
      push_column(8'h00, 8'hFF, 1'b1);
      push_column(8'hFF, 8'hFF, 1'b0);
      while (words_queued < WORD_TARGET) begin
         if (!long_done && words_queued > 400) begin
            // run past MAX_READ_LEN: high positions, then no calls as the count saturates
            push_random_read(LONG_READ_LEN, 1'b1);
            long_done = 1'b1;
         end else if ($urandom_range(99) < 85) begin
            if ($urandom_range(9) == 0)
               push_random_read($urandom_range(1, 3), 1'b1);
            else
               push_random_read($urandom_range(4, 40), 1'b1);
         end else begin
            push_random_read($urandom_range(1, 20), 1'b0);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // driver: predict on acceptance, then load the next word or go idle
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            predict_call(req_read_base, req_genome_base, req_first_of_read);
         // the slot frees when nothing is held or the held word is taken now
         if (!req_valid || req_ready) begin
            if (pending_columns.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
               next_column = pending_columns.pop_front();
               req_read_base <= next_column.read_base;
               req_genome_base <= next_column.genome_base;
               req_first_of_read <= next_column.first_of_read;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: check each result word against the oldest predicted call
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen_call.code = rsp_call_code;
            seen_call.position = rsp_call_position;
            if (expected_calls.size() == 0) begin
               report_mismatch($sformatf("result word with no call pending (code %0d pos %0d)",
                                         seen_call.code, seen_call.position));
            end else begin
               oldest_call = expected_calls.pop_front();
               if (seen_call.code !== oldest_call.code)
                  report_mismatch($sformatf("call_code %0d, predicted %0d",
                                            seen_call.code, oldest_call.code));
               if (seen_call.position !== oldest_call.position)
                  report_mismatch($sformatf("call_position %0d, predicted %0d",
                                            seen_call.position, oldest_call.position));
            end
         end
         rsp_ready <= calm || ($urandom_range(99) >= 33);
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: end the run if neither channel moves a word for too long
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      genome_hist[0] = '0;
      genome_hist[1] = '0;
      read_hist[0] = '0;
      read_hist[1] = '0;
      column_total = '0;
      build_stimulus();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // hold until every column is taken and every call has come back
      while (pending_columns.size() != 0 || req_valid) @(posedge clock);
      while (expected_calls.size() != 0) @(posedge clock);
      // let any stray result word show itself
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_calls.size() != 0)
         report_mismatch($sformatf("%0d calls never returned", expected_calls.size()));
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== methylation_context_caller_unit.f =====
design/mcc_pkg.sv
design/mcc_window.sv
design/mcc_classify.sv
design/methylation_context_caller_unit.sv
tb/tb.sv
